>>> rtl/cmae_pkg.sv
package cmae_pkg;

  localparam int unsigned O1_DEPTH  = 65536;
  localparam int unsigned O1_AW     = 16;
  localparam int unsigned O0_DEPTH  = 256;
  localparam int unsigned SSE_BKT   = 17;
  localparam int unsigned SSE_DEPTH = 2 * 256 * SSE_BKT;
  localparam int unsigned SSE_AW    = 14;

  localparam logic [1:0] CMD_MODEL = 2'd0;
  localparam logic [1:0] CMD_RAW   = 2'd1;
  localparam logic [1:0] CMD_FLUSH = 2'd2;

  localparam logic [15:0] CNT_INIT = 16'h8000;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  function automatic logic [15:0] adapt(input logic [15:0] v, input logic one,
                                        input int unsigned rate);
    logic [15:0] r;
    if (one) r = v + ((v ^ 16'hFFFF) >> rate);
    else     r = v - (v >> rate);
    return r;
  endfunction

endpackage

>>> rtl/context_model_arithmetic_encoder.sv
// Byte-in, byte-out context-mixing binary arithmetic encoder. After reset the block sweeps its
// counter and SSE memories before in_ready rises. A modeled byte codes each of its 8 bits
// through the steps counter read, mix, SSE read, interpolate, range multiply, update and
// first SSE write, second SSE write and normalize check, emits finished bytes during the
// normalize check and then closes the transaction; a raw byte codes each bit through range
// multiply, update and normalize check; a flush shifts out four bytes of low and closes.
// Output backpressure can stall emission. The per-bit read-modify-write of the counter memories
// dictates this step sequence. The final output byte of each input transaction carries last.
module context_model_arithmetic_encoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cmae_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cmae_pkg::out_item_t out_data
);
  import cmae_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_MIX   = 4'd3;
  localparam logic [3:0] S_SRD   = 4'd4;
  localparam logic [3:0] S_SSE   = 4'd5;
  localparam logic [3:0] S_PROD  = 4'd6;
  localparam logic [3:0] S_MID   = 4'd7;
  localparam logic [3:0] S_WB2   = 4'd8;
  localparam logic [3:0] S_NORM  = 4'd9;
  localparam logic [3:0] S_FLUSH = 4'd10;
  localparam logic [3:0] S_END   = 4'd11;

  logic [15:0] o0_mem [O0_DEPTH];
  logic [15:0] o1_mem [O1_DEPTH];
  logic [15:0] sse_mem [SSE_DEPTH];

  logic [3:0]  state_r, state_nxt;
  logic [15:0] clr_r;
  logic [4:0]  k_r;
  logic [31:0] low_r, low_nxt, high_r, high_nxt;
  logic [7:0]  prev_r, pp_r, ctx_r, dat_r;
  logic [1:0]  run_r, cnt4_r;
  logic        raw_r, f_r, mdl_r;
  logic [2:0]  bit_r;
  logic [15:0] p_r, c0_r, c1_r, x1_r, x2_r, sse_r;
  logic [SSE_AW-1:0] base_r;
  logic [49:0] prod_r;
  logic        pend_v_r;
  logic [7:0]  pend_r;
  logic        out_valid_r;
  out_item_t   out_r;

  logic [15:0] c0_rd, c1_rd, p2_rd, x1_rd, x2_rd;
  logic        o0_we, o1_we, sse_we;
  logic [7:0]  o0_wa;
  logic [O1_AW-1:0] o1_wa;
  logic [SSE_AW-1:0] sse_wa, sse_ra;
  logic [15:0] o0_wd, o1_wd, sse_wd, k_val;
  logic        one, out_free, norm_need, out_load;
  logic [19:0] mix;
  logic [16:0] diff;
  logic [29:0] iprod;
  logic [17:0] sse_s, prob;
  logic [31:0] span, mid;
  logic [SSE_AW-1:0] base_c;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;
  assign out_load  = pend_v_r && out_free &&
                     (((state_r == S_NORM) && norm_need) || (state_r == S_FLUSH) ||
                      (state_r == S_END));
  assign one       = dat_r[7];
  assign k_val     = (k_r == 5'd16) ? 16'hFFFF : {k_r[3:0], 12'h000};

  assign sse_ra = (state_r == S_SRD) ? base_c : base_r;
  assign base_c = SSE_AW'({f_r, ctx_r} * 9'd17) + SSE_AW'(p_r[15:12]);

  always_ff @(posedge clk) begin
    if (o0_we) o0_mem[o0_wa] <= o0_wd;
    c0_rd <= o0_mem[ctx_r];
  end

  always_ff @(posedge clk) begin
    if (o1_we) o1_mem[o1_wa] <= o1_wd;
    c1_rd <= o1_mem[{prev_r, ctx_r}];
    p2_rd <= o1_mem[{pp_r, ctx_r}];
  end

  always_ff @(posedge clk) begin
    if (sse_we) sse_mem[sse_wa] <= sse_wd;
    x1_rd <= sse_mem[sse_ra];
    x2_rd <= sse_mem[sse_ra + SSE_AW'(1)];
  end

  always_comb begin
    o0_we  = 1'b0;
    o1_we  = 1'b0;
    sse_we = 1'b0;
    o0_wa  = ctx_r;
    o1_wa  = {prev_r, ctx_r};
    sse_wa = base_r;
    o0_wd  = adapt(c0_r, one, 2);
    o1_wd  = adapt(c1_r, one, 4);
    sse_wd = adapt(x1_r, one, 6);
    if (state_r == S_CLEAR) begin
      o0_wa  = clr_r[7:0];
      o1_wa  = clr_r;
      sse_wa = clr_r[SSE_AW-1:0];
      o0_wd  = CNT_INIT;
      o1_wd  = CNT_INIT;
      sse_wd = k_val;
      o0_we  = (clr_r < 16'(O0_DEPTH));
      o1_we  = 1'b1;
      sse_we = (clr_r < 16'(SSE_DEPTH));
    end else if (state_r == S_MID && !raw_r) begin
      o0_we  = 1'b1;
      o1_we  = 1'b1;
      sse_we = 1'b1;
    end else if (state_r == S_WB2) begin
      sse_wa = base_r + SSE_AW'(1);
      sse_wd = adapt(x2_r, one, 6);
      sse_we = 1'b1;
    end
  end

  always_comb begin
    mix   = ((20'(c0_rd) + 20'(c1_rd)) * 20'd7) + 20'(p2_rd) + 20'(p2_rd);
    diff  = 17'(x2_rd) - 17'(x1_rd);
    iprod = 30'($signed(diff) * $signed({1'b0, p_r[11:0]}));
    sse_s = 18'(x1_rd) + 18'($signed(iprod) >>> 12);
    prob  = 18'(p_r) + 18'(sse_r) + 18'(sse_r) + 18'(sse_r);
    span  = high_r - low_r;
    mid   = low_r + prod_r[49:18];
    norm_need = ((low_r ^ high_r) < 32'h0100_0000);
  end

  always_comb begin
    state_nxt = state_r;
    low_nxt   = low_r;
    high_nxt  = high_r;
    case (state_r)
      S_CLEAR: if (clr_r == 16'hFFFF) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          case (in_data.cmd)
            CMD_MODEL: state_nxt = S_RD;
            CMD_RAW:   state_nxt = S_PROD;
            CMD_FLUSH: state_nxt = S_FLUSH;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_RD:   state_nxt = S_MIX;
      S_MIX:  state_nxt = S_SRD;
      S_SRD:  state_nxt = S_SSE;
      S_SSE:  state_nxt = S_PROD;
      S_PROD: state_nxt = S_MID;
      S_MID: begin
        if (one) high_nxt = mid;
        else     low_nxt  = mid + 32'd1;
        state_nxt = raw_r ? S_NORM : S_WB2;
      end
      S_WB2: state_nxt = S_NORM;
      S_NORM: begin
        if (norm_need) begin
          if (!pend_v_r || out_free) begin
            low_nxt  = {low_r[23:0], 8'h00};
            high_nxt = {high_r[23:0], 8'hFF};
          end
        end else if (bit_r == 3'd7) begin
          state_nxt = S_END;
        end else begin
          state_nxt = raw_r ? S_PROD : S_RD;
        end
      end
      S_FLUSH: begin
        if (!pend_v_r || out_free) begin
          low_nxt = {low_r[23:0], 8'h00};
          if (cnt4_r == 2'd3) state_nxt = S_END;
        end
      end
      S_END: if (!pend_v_r || out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      k_r         <= '0;
      low_r       <= '0;
      high_r      <= '1;
      prev_r      <= '0;
      pp_r        <= '0;
      run_r       <= '0;
      ctx_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      bit_r       <= '0;
      cnt4_r      <= '0;
      raw_r       <= 1'b0;
      f_r         <= 1'b0;
      mdl_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      low_r   <= low_nxt;
      high_r  <= high_nxt;
      if (out_load)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 16'd1;
          k_r   <= (k_r == 5'd16) ? 5'd0 : k_r + 5'd1;
        end
        S_IDLE: begin
          dat_r  <= in_data.data;
          ctx_r  <= (in_data.cmd == CMD_MODEL) ? 8'd1 : ctx_r;
          raw_r  <= (in_data.cmd == CMD_RAW);
          mdl_r  <= (in_data.cmd == CMD_MODEL);
          f_r    <= (run_r == 2'd3);
          bit_r  <= '0;
          cnt4_r <= '0;
        end
        S_MIX: begin
          p_r  <= mix[19:4];
          c0_r <= c0_rd;
          c1_r <= c1_rd;
        end
        S_SRD: base_r <= base_c;
        S_SSE: begin
          sse_r <= sse_s[15:0];
          x1_r  <= x1_rd;
          x2_r  <= x2_rd;
        end
        S_PROD: begin
          if (raw_r) prod_r <= {1'b0, span, 17'h00000};
          else       prod_r <= 50'(span) * 50'(prob);
        end
        S_NORM: begin
          if (norm_need) begin
            if (!pend_v_r || out_free) begin
              if (pend_v_r) out_r <= '{out_byte: pend_r, last: 1'b0};
              pend_r   <= low_r[31:24];
              pend_v_r <= 1'b1;
            end
          end else begin
            bit_r <= bit_r + 3'd1;
            dat_r <= {dat_r[6:0], 1'b0};
            ctx_r <= {ctx_r[6:0], one};
          end
        end
        S_FLUSH: begin
          if (!pend_v_r || out_free) begin
            if (pend_v_r) out_r <= '{out_byte: pend_r, last: 1'b0};
            pend_r   <= low_r[31:24];
            pend_v_r <= 1'b1;
            cnt4_r   <= cnt4_r + 2'd1;
          end
        end
        S_END: begin
          if (!pend_v_r || out_free) begin
            if (pend_v_r) out_r <= '{out_byte: pend_r, last: 1'b1};
            pend_v_r <= 1'b0;
            if (mdl_r) begin
              pp_r   <= prev_r;
              prev_r <= ctx_r;
              if (ctx_r == prev_r) run_r <= (run_r == 2'd3) ? run_r : run_r + 2'd1;
              else                 run_r <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import cmae_pkg::*;

  localparam longint CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  always #10 clk = ~clk;

  context_model_arithmetic_encoder dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  logic [31:0] enc_low, enc_high;
  logic [15:0] o0_cnt [0:255];
  logic [15:0] o1_cnt [0:65535];
  logic [15:0] sse_cnt [0:SSE_DEPTH-1];
  logic [7:0] last_byte, last_byte2;
  logic [1:0] run_len;

  out_item_t byte_q[$];
  int n_errors = 0;
  longint cycles = 0;
  logic drain_phase = 1'b0;
  logic quiet = 1'b0;

  task automatic report(input string what, input out_item_t got, input out_item_t exp);
    $display("mismatch %s: got %02h/%0b expected %02h/%0b", what,
             got.out_byte, got.last, exp.out_byte, exp.last);
    n_errors++;
  endtask

  function automatic logic [15:0] shift_adapt(input logic [15:0] v, input logic one,
                                              input int r);
    if (one) return v + ((v ^ 16'hFFFF) >> r);
    return v - (v >> r);
  endfunction

  task automatic model_reset();
    enc_low = '0;
    enc_high = '1;
    for (int t = 0; t < 256; t++) o0_cnt[t] = CNT_INIT;
    for (int t = 0; t < 65536; t++) o1_cnt[t] = CNT_INIT;
    for (int t = 0; t < 512; t++)
      for (int k = 0; k < SSE_BKT; k++)
        sse_cnt[t*SSE_BKT+k] = 16'((k << 12) - (k == 16 ? 1 : 0));
    last_byte = '0;
    last_byte2 = '0;
    run_len = '0;
  endtask

  task automatic code_bit(input logic one, input logic [31:0] prob, input int sh,
                          inout out_item_t res[$]);
    logic [63:0] prod;
    logic [31:0] mid;
    out_item_t r;
    prod = {32'd0, enc_high - enc_low} * {32'd0, prob};
    mid = enc_low + 32'(prod >> sh);
    if (one) enc_high = mid;
    else enc_low = mid + 32'd1;
    while ((enc_low ^ enc_high) < 32'h0100_0000) begin
      r.out_byte = enc_low[31:24];
      r.last = 1'b0;
      res.push_back(r);
      enc_low = enc_low << 8;
      enc_high = (enc_high << 8) | 32'hFF;
    end
  endtask

  task automatic predict(input in_item_t it);
    out_item_t res[$];
    out_item_t r;
    int ctx, j, base, f;
    logic one;
    logic [31:0] p, p2;
    longint x1, x2, pr, sse;
    if (it.cmd == CMD_MODEL) begin
      f = (run_len == 2'd3);
      ctx = 1;
      for (int i = 0; i < 8; i++) begin
        one = it.data[7-i];
        p2 = o1_cnt[{last_byte2, 8'(ctx)}];
        p = (((o0_cnt[ctx & 255] + o1_cnt[{last_byte, 8'(ctx)}]) * 7) + p2 + p2) >> 4;
        j = p >> 12;
        if (j > SSE_BKT - 2) j = SSE_BKT - 2;
        base = (f * 256 + (ctx & 255)) * SSE_BKT + j;
        x1 = sse_cnt[base];
        x2 = sse_cnt[base+1];
        pr = (x2 - x1) * longint'(p & 4095);
        if (pr >= 0) sse = x1 + pr / 4096;
        else sse = x1 - ((-pr + 4095) / 4096);
        code_bit(one, p + 3 * 32'(sse), 18, res);
        o0_cnt[ctx & 255] = shift_adapt(o0_cnt[ctx & 255], one, 2);
        o1_cnt[{last_byte, 8'(ctx)}] = shift_adapt(o1_cnt[{last_byte, 8'(ctx)}], one, 4);
        sse_cnt[base] = shift_adapt(sse_cnt[base], one, 6);
        sse_cnt[base+1] = shift_adapt(sse_cnt[base+1], one, 6);
        ctx = (ctx << 1) | one;
      end
      last_byte2 = last_byte;
      last_byte = 8'(ctx);
      if (last_byte == last_byte2) begin
        if (run_len != 2'd3) run_len++;
      end else begin
        run_len = '0;
      end
    end else if (it.cmd == CMD_RAW) begin
      for (int i = 7; i >= 0; i--) code_bit(it.data[i], 32'd1, 1, res);
    end else if (it.cmd == CMD_FLUSH) begin
      for (int i = 0; i < 4; i++) begin
        r.out_byte = enc_low[31:24];
        r.last = 1'b0;
        res.push_back(r);
        enc_low = enc_low << 8;
      end
    end
    if (res.size() > 32) res = res[0:31];
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[k]) byte_q.push_back(res[k]);
  endtask

  task automatic send(input in_item_t it);
    while (!quiet && !drain_phase && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict(it);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (byte_q.size() == 0) begin
        report("unexpected", out_data, '0);
      end else begin
        if (out_data !== byte_q[0]) report("field", out_data, byte_q[0]);
        void'(byte_q.pop_front());
      end
    end
  end

  initial begin
    int burst;
    forever begin
      @(posedge clk);
      if (drain_phase || quiet) begin
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 17);
        out_ready <= 1'b0;
        repeat (burst) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  in_item_t table_q[$];
  in_item_t it;
  logic [7:0] rep;

  initial begin
    model_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    table_q = '{
      '{CMD_FLUSH, 8'h00},
      '{CMD_MODEL, 8'h00}, '{CMD_MODEL, 8'hFF}, '{CMD_MODEL, 8'hAA},
      '{CMD_MODEL, 8'h55}, '{CMD_MODEL, 8'h41}, '{CMD_MODEL, 8'h41},
      '{CMD_MODEL, 8'h41}, '{CMD_MODEL, 8'h41}, '{CMD_MODEL, 8'h41},
      '{CMD_MODEL, 8'h42}, '{CMD_RAW, 8'h00}, '{CMD_RAW, 8'hFF},
      '{CMD_RAW, 8'hDE}, '{CMD_RAW, 8'hAD}, '{CMD_RAW, 8'hBE}, '{CMD_RAW, 8'hEF},
      '{2'd3, 8'h5A}, '{2'd3, 8'hFF}, '{CMD_FLUSH, 8'hFF}, '{CMD_FLUSH, 8'h00}
    };
    foreach (table_q[i]) send(table_q[i]);
    in_valid <= 1'b0;
    do @(posedge clk); while (byte_q.size() != 0);
    for (int n = 0; n < 150; n++) begin
      if (n == 120) drain_phase = 1'b1;
      if (n == 60) begin
        quiet = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (byte_q.size() != 0);
        quiet = 1'b0;
      end
      case ($urandom_range(0, 19))
        0, 1: it = '{CMD_RAW, 8'($urandom)};
        2: it = '{CMD_FLUSH, 8'($urandom)};
        3: it = '{2'd3, 8'($urandom)};
        4, 5, 6, 7: begin
          rep = 8'($urandom_range(60, 70));
          it = '{CMD_MODEL, rep};
        end
        default: it = '{CMD_MODEL, 8'($urandom)};
      endcase
      send(it);
    end
    send('{CMD_FLUSH, 8'h00});
    in_valid <= 1'b0;
    while (byte_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (n_errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

>>> context_model_arithmetic_encoder.f
rtl/cmae_pkg.sv
rtl/context_model_arithmetic_encoder.sv
verif/tb.sv
